@@ hdl/lgbd_pkg.sv @@
package lgbd_pkg;

   localparam int PosW     = 17;
   localparam int CoordW   = 10;
   localparam int ColorW   = 9;
   localparam int BeamW    = 9;
   localparam int LightW   = 13;
   localparam int TrigW    = 2;
   localparam int OffsetW  = 4;
   localparam int PortW    = 5;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 13;
   localparam int ReqDataW = 48;
   localparam int RspDataW = 32;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LIGHT_HOLD    = 2'd0,
      CSR_TRIGGER_HOLD  = 2'd1,
      CSR_TARGET_OFFSET = 2'd2
   } csr_index_type;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [LightW-1:0]  LIGHT_HOLD_RESET    = 13'd5456;
   localparam logic [TrigW-1:0]   TRIGGER_HOLD_RESET  = 2'd2;
   localparam logic [OffsetW-1:0] TARGET_OFFSET_RESET = 4'd3;

   localparam logic signed [CoordW-1:0] COL_RESET = 10'sd128;
   localparam logic signed [CoordW-1:0] ROW_RESET = 10'sd120;

   localparam logic signed [CoordW-1:0] SCREEN_W = 10'sd256;
   localparam logic signed [CoordW-1:0] SCREEN_H = 10'sd240;

   localparam logic signed [CoordW:0] COL_MIN = -11'sd16;
   localparam logic signed [CoordW:0] COL_MAX = 11'sd272;
   localparam logic signed [CoordW:0] ROW_MIN = -11'sd16;
   localparam logic signed [CoordW:0] ROW_MAX = 11'sd256;

   localparam int          BRIGHT_BIT   = 5;
   localparam logic [3:0]  BRIGHT_LIMIT = 4'hD;

   localparam int PORT_TRIGGER_BIT = 4;
   localparam int PORT_DARK_BIT    = 3;

   typedef struct packed {
      logic                     kind;
      logic [PosW-1:0]          pos;
      logic [ColorW-1:0]        pixel_color;
      logic signed [CoordW-1:0] delta_x;
      logic signed [CoordW-1:0] delta_y;
      logic                     trigger_pressed;
   } item_type;

   typedef struct packed {
      logic signed [CoordW-1:0] cursor_col;
      logic signed [CoordW-1:0] cursor_row;
      logic                     outside;
      logic [LightW-1:0]        light_count;
      logic [TrigW-1:0]         trigger_count;
      logic                     trigger_lock;
      logic [PosW-1:0]          last_position;
   } state_type;

   typedef struct packed {
      logic [LightW-1:0]  light_hold;
      logic [TrigW-1:0]   trigger_hold;
      logic [OffsetW-1:0] target_offset;
   } cfg_type;

   typedef struct packed {
      logic [PortW-1:0]         port_value;
      logic signed [CoordW-1:0] cursor_x;
      logic signed [CoordW-1:0] cursor_y;
      logic                     off_screen;
   } result_type;

   function automatic logic signed [CoordW-1:0] clamp_coord(
      input logic signed [CoordW:0] v,
      input logic signed [CoordW:0] lo,
      input logic signed [CoordW:0] hi
   );
      logic signed [CoordW:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r[CoordW-1:0];
   endfunction

endpackage

@@ hdl/lgbd_req_stage.sv @@
module lgbd_req_stage #(
   parameter int DOTS_PER_LINE = 341
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,  // kind
   // beam_line, beam_dot, pixel_color, delta_x, delta_y, trigger_pressed
   input  logic [lgbd_pkg::ReqDataW-1:0]   req_tdata,
   input  logic                            advance,
   output logic                            item_valid,
   output lgbd_pkg::item_type              item
);
   import lgbd_pkg::*;

   localparam logic [PosW-1:0] Dots = PosW'(DOTS_PER_LINE);

   logic            valid_ff, valid_in;
   item_type        item_ff, item_in;
   logic [PosW-1:0] line_ext, dot_ext;

   assign req_tready = !valid_ff || advance;

   // raster position of the beam, wrapping to the position width
   assign line_ext = PosW'(req_tdata[BeamW-1:0]);
   assign dot_ext  = PosW'(req_tdata[2*BeamW-1:BeamW]);

   always_comb begin
      valid_in = req_tready ? req_tvalid : valid_ff;
      item_in.kind            = req_tuser;
      item_in.pos             = line_ext * Dots + dot_ext;
      item_in.pixel_color     = req_tdata[26:18];
      item_in.delta_x         = req_tdata[36:27];
      item_in.delta_y         = req_tdata[46:37];
      item_in.trigger_pressed = req_tdata[47];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/lgbd_update.sv @@
module lgbd_update #(
   parameter int DOTS_PER_LINE = 341
) (
   input  lgbd_pkg::item_type   item,
   input  lgbd_pkg::state_type  state,
   input  lgbd_pkg::cfg_type    cfg,
   output lgbd_pkg::state_type  state_next,
   output lgbd_pkg::result_type result
);
   import lgbd_pkg::*;

   localparam logic [PosW-1:0] Dots = PosW'(DOTS_PER_LINE);

   logic [PosW-1:0]        target;
   logic                   bright, hit, wrap;
   logic signed [CoordW:0] sum_x, sum_y;
   logic signed [CoordW-1:0] new_col, new_row;
   logic [PortW-1:0]       port;

   // target only matters while the cursor is on screen, so row and col are non-negative
   assign target = PosW'(state.cursor_row[CoordW-1:0]) * Dots
                 + PosW'(state.cursor_col[CoordW-1:0])
                 + PosW'(cfg.target_offset);

   assign bright = item.pixel_color[BRIGHT_BIT] && (item.pixel_color[3:0] < BRIGHT_LIMIT);
   assign hit    = !state.outside && (item.pos >= target) && (state.last_position < target)
                 && bright;
   assign wrap   = item.pos < state.last_position;

   assign sum_x   = {state.cursor_col[CoordW-1], state.cursor_col}
                  + {item.delta_x[CoordW-1], item.delta_x};
   assign sum_y   = {state.cursor_row[CoordW-1], state.cursor_row}
                  + {item.delta_y[CoordW-1], item.delta_y};
   assign new_col = clamp_coord(sum_x, COL_MIN, COL_MAX);
   assign new_row = clamp_coord(sum_y, ROW_MIN, ROW_MAX);

   always_comb begin
      state_next = state;
      port       = '0;
      if (item.kind == KIND_READ) begin
         if (item.trigger_pressed && !state.trigger_lock) begin
            state_next.trigger_count = cfg.trigger_hold;
            state_next.trigger_lock  = 1'b1;
         end else if (!item.trigger_pressed) begin
            state_next.trigger_lock = 1'b0;
         end
         port[PORT_TRIGGER_BIT] = state_next.trigger_count != '0;
         port[PORT_DARK_BIT]    = state_next.light_count == '0;
      end else begin
         if (state.light_count != '0) begin
            state_next.light_count = state.light_count - 1'b1;
         end
         if (hit) begin
            state_next.light_count = cfg.light_hold;
         end
         if (wrap) begin
            if (state.trigger_count != '0) begin
               state_next.trigger_count = state.trigger_count - 1'b1;
            end
            state_next.cursor_col = new_col;
            state_next.cursor_row = new_row;
            state_next.outside    = new_col[CoordW-1] || new_row[CoordW-1]
                                  || (new_col >= SCREEN_W) || (new_row >= SCREEN_H);
         end
         state_next.last_position = item.pos;
      end
   end

   always_comb begin
      result.port_value = port;
      result.cursor_x   = state_next.cursor_col;
      result.cursor_y   = state_next.cursor_row;
      result.off_screen = state_next.outside;
   end

endmodule

@@ hdl/light_gun_beam_detector_core.sv @@
// Light gun beam detector core.
// Requests arrive on the req_ channel: req_tuser is the kind (0 = tick of two
// dots, 1 = port read), req_tdata carries beam line/dot, pixel colour, motion
// deltas and the trigger level. Each request gives exactly one response on the
// rsp_ channel with the port bits, the clamped cursor and the off-screen flag.
// A request is registered in the request register on acceptance, and its response
// is written to the output register, with rsp_tvalid, when the request leaves it.
// One request is taken every cycle while the response is not stalled: the
// cursor and counter update is a single combinational pass from the request
// register into the state and response registers, set by the beam position
// multiply and compares.
// When the receiver stalls the response holds, one more request is held in the
// request register, and req_tready then drops until rsp_tready returns.
// Synchronous reset empties both registers, sets the cursor to 128,120 on
// screen, clears the light and trigger counters and loads the register
// defaults (light hold 5456, trigger hold 2, target offset 3).
// csr_ writes are taken on any cycle with csr_we high; index 3 is ignored.
module light_gun_beam_detector_core #(
   parameter int DOTS_PER_LINE = 341
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,  // kind
   // beam_line, beam_dot, pixel_color, delta_x, delta_y, trigger_pressed
   input  logic [lgbd_pkg::ReqDataW-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // port_value, cursor_x, cursor_y, off_screen, zero fill
   output logic [lgbd_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [lgbd_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [lgbd_pkg::CsrDataW-1:0]   csr_wdata
);
   import lgbd_pkg::*;

   logic       advance, item_valid, fire;
   item_type   item;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = item_valid && advance;

   lgbd_req_stage #(
      .DOTS_PER_LINE(DOTS_PER_LINE)
   ) u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lgbd_update #(
      .DOTS_PER_LINE(DOTS_PER_LINE)
   ) u_update (
      .item       (item),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_HOLD:    cfg_in.light_hold    = csr_wdata[LightW-1:0];
            CSR_TRIGGER_HOLD:  cfg_in.trigger_hold  = csr_wdata[TrigW-1:0];
            CSR_TARGET_OFFSET: cfg_in.target_offset = csr_wdata[OffsetW-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_hold    <= LIGHT_HOLD_RESET;
         cfg_ff.trigger_hold  <= TRIGGER_HOLD_RESET;
         cfg_ff.target_offset <= TARGET_OFFSET_RESET;
         state_ff.cursor_col    <= COL_RESET;
         state_ff.cursor_row    <= ROW_RESET;
         state_ff.outside       <= 1'b0;
         state_ff.light_count   <= '0;
         state_ff.trigger_count <= '0;
         state_ff.trigger_lock  <= 1'b0;
         state_ff.last_position <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.off_screen, rsp_data_ff.cursor_y,
                        rsp_data_ff.cursor_x, rsp_data_ff.port_value};

   // off-screen flag follows the stored cursor
   a_outside_consistent: assert property (@(posedge clock) disable iff (reset)
      state_ff.outside == (state_ff.cursor_col[CoordW-1] || state_ff.cursor_row[CoordW-1]
         || (state_ff.cursor_col >= SCREEN_W) || (state_ff.cursor_row >= SCREEN_H)))
      else $error("off-screen flag disagrees with cursor");

   a_cursor_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cursor_col >= CoordW'(COL_MIN)) && (state_ff.cursor_col <= CoordW'(COL_MAX))
      && (state_ff.cursor_row >= CoordW'(ROW_MIN)) && (state_ff.cursor_row <= CoordW'(ROW_MAX)))
      else $error("cursor outside clamp range");

   // back-pressure only ever comes from a stalled response
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a stalled response");

   a_response_follows_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request gave no response");

endmodule
